@@ rtl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// SSI encoder reader package
// Widths, reset values, phase codes and the words passed between stages.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int unsigned CODE_W     = 14;
  localparam int unsigned DATA_BITS  = 14;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned HALF_W     = 10;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned READS_DEF  = 10;

  // floor(n / d) = (n * DIV_MULT) >> DIV_SHIFT for n < 2**SUM_W, d < 16
  localparam int unsigned DIV_SHIFT  = SUM_W + FRAME_W;
  localparam int unsigned DIV_MULT_W = DIV_SHIFT + 1;

  localparam logic [SCALE_W-1:0] ANGLE_SCALE     = 16'd36000;
  localparam logic [CODE_W-1:0]  ZERO_OFFSET_RST = 14'd9149;
  localparam logic [HALF_W-1:0]  HALF_PERIOD_RST = 10'd5;

  typedef enum logic {
    REG_ZERO_OFFSET = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_DESEL  = 7'b0000010,
    PH_SEL    = 7'b0000100,
    PH_DUM_HI = 7'b0001000,
    PH_DUM_LO = 7'b0010000,
    PH_BIT_HI = 7'b0100000,
    PH_BIT_LO = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic data_level;
  } req_word_t;

  typedef struct packed {
    logic               clock_out;
    logic               select_out;
    logic               done_res;
    logic [CODE_W-1:0]  position;
    logic [CODE_W-1:0]  angle_code;
    logic [ANGLE_W-1:0] angle_centi_degrees;
  } rsp_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] zero_offset;
    logic [HALF_W-1:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             clock;
    logic             select;
    logic             done;
    logic [SUM_W-1:0] sum;
  } ctl_word_t;

  typedef struct packed {
    logic valid;
    logic clock;
    logic select;
    logic done;
  } lvl_word_t;

endpackage

@@ rtl/ssi_encoder_reader_averaging.sv @@
// ----------------------------------------------------------------------------
// SSI encoder reader with frame averaging
// Pipeline: each word taken on req is registered in s1, then in s2, then onto rsp.
// Throughput: one word per cycle; the three stages stall together on rsp_ready.
// Reset clears the sequencer to idle, the held average to zero, the pipeline
// to empty and the registers to zero offset 9149, half period 5.
// ----------------------------------------------------------------------------
module ssi_encoder_reader_averaging #(
  parameter int unsigned READS = ssi_pkg::READS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  ssi_pkg::req_word_t             req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output ssi_pkg::rsp_word_t             rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssi_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssi_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ssi_pkg::*;

  cfg_t              cfg;
  ctl_word_t         s1;
  lvl_word_t         s2;
  logic [CODE_W-1:0] hold;
  logic              adv;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  ssi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssi_ctrl #(.READS(READS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg),
    .s1        (s1)
  );

  ssi_avg #(.READS(READS)) u_avg (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .s1   (s1),
    .s2   (s2),
    .hold (hold)
  );

  ssi_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s2        (s2),
    .hold      (hold),
    .cfg       (cfg),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

@@ rtl/ssi_cfg.sv @@
// ----------------------------------------------------------------------------
// SSI configuration registers
// APB-style write/read of zero offset and clock half period.
// ----------------------------------------------------------------------------
module ssi_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssi_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssi_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output ssi_pkg::cfg_t                  cfg
);
  import ssi_pkg::*;

  logic [CODE_W-1:0] zero_offset;
  logic [HALF_W-1:0] half_period_ticks;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset       <= ZERO_OFFSET_RST;
      half_period_ticks <= HALF_PERIOD_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_ZERO_OFFSET: zero_offset       <= pwdata[CODE_W-1:0];
        REG_HALF_PERIOD: half_period_ticks <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_OFFSET: prdata = APB_DATA_W'(zero_offset);
      REG_HALF_PERIOD: prdata = APB_DATA_W'(half_period_ticks);
      default:         prdata = '0;
    endcase
  end

  assign cfg.zero_offset       = zero_offset;
  assign cfg.half_period_ticks = half_period_ticks;

endmodule

@@ rtl/ssi_ctrl.sv @@
// ----------------------------------------------------------------------------
// SSI frame sequencer
// Select/clock phase machine, bit capture and frame summing, one tick a word.
// ----------------------------------------------------------------------------
module ssi_ctrl #(
  parameter int unsigned READS = ssi_pkg::READS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               req_valid,
  input  ssi_pkg::req_word_t req,
  input  ssi_pkg::cfg_t      cfg,
  output ssi_pkg::ctl_word_t s1
);
  import ssi_pkg::*;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_counter, tick_counter_next;
  logic [BIT_W-1:0]    bit_counter, bit_counter_next;
  logic [FRAME_W-1:0]  frame_counter, frame_counter_next;
  logic [CODE_W-1:0]   shift_register, shift_register_next;
  logic [SUM_W-1:0]    frame_sum, frame_sum_next;
  logic [HALF_W-1:0]   half;
  logic [TICK_W:0]     tick_inc;
  logic [BIT_W-1:0]    bit_inc;
  logic                expire;
  logic                done;
  logic                clock_lvl;
  logic                select_lvl;
  logic                take;

  assign take       = adv && req_valid;
  assign half       = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
  assign tick_inc   = {1'b0, tick_counter} + (TICK_W+1)'(1);
  assign bit_inc    = bit_counter + BIT_W'(1);
  assign expire     = tick_inc >= (TICK_W+1)'(half);
  assign clock_lvl  = (phase == PH_DUM_HI) || (phase == PH_BIT_HI);
  assign select_lvl = (phase == PH_IDLE) || (phase == PH_DESEL);

  always_comb begin
    phase_next          = phase;
    tick_counter_next   = tick_counter;
    bit_counter_next    = bit_counter;
    frame_counter_next  = frame_counter;
    shift_register_next = shift_register;
    frame_sum_next      = frame_sum;
    done                = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (req.start_req) begin
          phase_next          = PH_DESEL;
          tick_counter_next   = '0;
          bit_counter_next    = '0;
          frame_counter_next  = '0;
          frame_sum_next      = '0;
          shift_register_next = '0;
        end
      end
      PH_DESEL, PH_SEL, PH_DUM_HI, PH_BIT_HI: begin
        if (expire) begin
          tick_counter_next = '0;
          case (phase)
            PH_DESEL: phase_next = PH_SEL;
            PH_SEL: begin
              phase_next       = PH_DUM_HI;
              bit_counter_next = '0;
            end
            PH_DUM_HI: phase_next = PH_DUM_LO;
            default:   phase_next = PH_BIT_LO;
          endcase
        end else begin
          tick_counter_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_DUM_LO: begin
        if (expire) begin
          tick_counter_next = '0;
          if (bit_inc >= BIT_W'(2)) begin
            bit_counter_next    = '0;
            shift_register_next = '0;
            phase_next          = PH_BIT_HI;
          end else begin
            bit_counter_next = bit_inc;
            phase_next       = PH_DUM_HI;
          end
        end else begin
          tick_counter_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_BIT_LO: begin
        if (tick_counter == '0) begin
          shift_register_next = {shift_register[CODE_W-2:0], req.data_level};
          if (bit_counter == BIT_W'(DATA_BITS - 1)) begin
            frame_sum_next     = frame_sum + SUM_W'(shift_register_next);
            frame_counter_next = frame_counter + FRAME_W'(1);
          end
        end
        if (expire) begin
          tick_counter_next = '0;
          if (bit_inc >= BIT_W'(DATA_BITS)) begin
            bit_counter_next = '0;
            if (frame_counter_next >= FRAME_W'(READS)) begin
              done       = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_DESEL;
            end
          end else begin
            bit_counter_next = bit_inc;
            phase_next       = PH_BIT_HI;
          end
        end else begin
          tick_counter_next = tick_inc[TICK_W-1:0];
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_counter   <= '0;
      bit_counter    <= '0;
      frame_counter  <= '0;
      shift_register <= '0;
      frame_sum      <= '0;
    end else if (take) begin
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      bit_counter    <= bit_counter_next;
      frame_counter  <= frame_counter_next;
      shift_register <= shift_register_next;
      frame_sum      <= frame_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.clock  <= clock_lvl;
      s1.select <= select_lvl;
      s1.done   <= done;
      s1.sum    <= frame_sum_next;
    end
  end

endmodule

@@ rtl/ssi_avg.sv @@
// ----------------------------------------------------------------------------
// SSI averaging stage
// Divides the frame sum by READS (reciprocal multiply) and holds the result.
// ----------------------------------------------------------------------------
module ssi_avg #(
  parameter int unsigned READS = ssi_pkg::READS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  ssi_pkg::ctl_word_t            s1,
  output ssi_pkg::lvl_word_t            s2,
  output logic [ssi_pkg::CODE_W-1:0]    hold
);
  import ssi_pkg::*;

  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'((64'd1 << DIV_SHIFT) / READS + 64'd1);

  logic [SUM_W+DIV_MULT_W-1:0] prod;
  logic [CODE_W-1:0]           quotient;

  assign prod     = (SUM_W+DIV_MULT_W)'(s1.sum) * (SUM_W+DIV_MULT_W)'(DIV_MULT);
  assign quotient = prod[DIV_SHIFT +: CODE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      hold     <= '0;
    end else if (adv) begin
      s2.valid <= s1.valid;
      if (s1.valid && s1.done) begin
        hold <= quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.clock  <= s1.clock;
      s2.select <= s1.select;
      s2.done   <= s1.done;
    end
  end

endmodule

@@ rtl/ssi_conv.sv @@
// ----------------------------------------------------------------------------
// SSI angle conversion
// Offset correction, centi-degree scaling and the output word register.
// ----------------------------------------------------------------------------
module ssi_conv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  ssi_pkg::lvl_word_t         s2,
  input  logic [ssi_pkg::CODE_W-1:0] hold,
  input  ssi_pkg::cfg_t              cfg,
  output logic                       rsp_valid,
  output ssi_pkg::rsp_word_t         rsp
);
  import ssi_pkg::*;

  logic [CODE_W-1:0]         code;
  logic [CODE_W+SCALE_W-1:0] scaled;

  assign code   = hold - cfg.zero_offset;
  assign scaled = (CODE_W+SCALE_W)'(code) * (CODE_W+SCALE_W)'(ANGLE_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.clock_out           <= s2.clock;
      rsp.select_out          <= s2.select;
      rsp.done_res            <= s2.done;
      rsp.position            <= hold;
      rsp.angle_code          <= code;
      rsp.angle_centi_degrees <= scaled[CODE_W +: ANGLE_W];
    end
  end

endmodule
